[rtl/core/wuf_pkg.sv]
// wuf_pkg: shared types and constants for the weighted union-find engine.
// Used by wuf_alu, wuf_ctrl and weighted_union_find. No dependencies.
`default_nettype none

package wuf_pkg;

	localparam int SITE_W    = 10;            // width of a site index field
	localparam int SETS_W    = 11;            // width of the sets_left field
	localparam int SITE_SPAN = 2 ** SITE_W;   // sites the fields can address
	localparam int SITES_DEF = 1024;

	localparam logic REQ_FIND  = 1'b0;
	localparam logic REQ_UNION = 1'b1;

	typedef struct packed {
		logic              req_type;
		logic [SITE_W-1:0] site_p;
		logic [SITE_W-1:0] site_q;
	} req_t;

	typedef struct packed {
		logic [SITE_W-1:0] result_root;
		logic              merged;
		logic [SETS_W-1:0] sets_left;
	} rsp_t;

	typedef enum logic {
		ALU_SUB,
		ALU_ADD
	} alu_op_t;

endpackage

`default_nettype wire

[rtl/core/wuf_alu.sv]
// wuf_alu: the shared add / subtract-compare unit of the union-find engine.
// Depends on wuf_pkg for the operation code.
`default_nettype none

module wuf_alu #(
	parameter int DW = 11
) (
	input  wire wuf_pkg::alu_op_t op,
	input  wire logic [DW-1:0]    a,
	input  wire logic [DW-1:0]    b,
	output logic [DW:0]           res,
	output logic                  eq,
	output logic                  lt
);
	import wuf_pkg::*;

	logic [DW:0] diff;
	logic [DW:0] sum;

	assign diff = {1'b0, a} - {1'b0, b};
	assign sum  = {1'b0, a} + {1'b0, b};
	assign lt   = diff[DW];
	assign eq   = (diff == '0);

	always_comb begin
		case (op)
			ALU_ADD: res = sum;
			ALU_SUB: res = diff;
			default: res = diff;
		endcase
	end

endmodule

`default_nettype wire

[rtl/core/wuf_store.sv]
// wuf_store: parent-link and tree-weight memories, one shared read address
// with registered read data and one write port each. Depends on nothing but the clock.
`default_nettype none

module wuf_store #(
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH),
	localparam int WW = $clog2(DEPTH + 1)
) (
	input  wire logic          clk,
	input  wire logic [AW-1:0] rd_addr,
	input  wire logic          par_we,
	input  wire logic [AW-1:0] par_wa,
	input  wire logic [AW-1:0] par_wd,
	input  wire logic          wt_we,
	input  wire logic [AW-1:0] wt_wa,
	input  wire logic [WW-1:0] wt_wd,
	output logic [AW-1:0]      par_rd,
	output logic [WW-1:0]      wt_rd
);

	logic [AW-1:0] par_mem [DEPTH];
	logic [WW-1:0] wt_mem  [DEPTH];

	always_ff @(posedge clk) begin
		if (par_we) begin
			par_mem[par_wa] <= par_wd;
		end
		par_rd <= par_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (wt_we) begin
			wt_mem[wt_wa] <= wt_wd;
		end
		wt_rd <= wt_mem[rd_addr];
	end

endmodule

`default_nettype wire

[rtl/core/wuf_ctrl.sv]
// wuf_ctrl: sequencer of the union-find engine - clearing pass, root walks,
// weighted link, path flattening and the result register.
// Depends on wuf_pkg; drives wuf_store and wuf_alu.
`default_nettype none

module wuf_ctrl #(
	parameter int SITES = wuf_pkg::SITES_DEF,
	localparam int DEPTH = (SITES < wuf_pkg::SITE_SPAN) ? SITES : wuf_pkg::SITE_SPAN,
	localparam int AW = $clog2(DEPTH),
	localparam int WW = $clog2(DEPTH + 1),
	localparam int DW = (AW > WW) ? AW : WW,
	localparam int SW = $clog2(SITES + 1)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	output logic                  req_ready,
	input  wire wuf_pkg::req_t    req,
	output logic                  rsp_valid,
	input  wire logic             rsp_ready,
	output wuf_pkg::rsp_t         rsp,
	output logic [AW-1:0]         rd_addr,
	output logic                  par_we,
	output logic [AW-1:0]         par_wa,
	output logic [AW-1:0]         par_wd,
	output logic                  wt_we,
	output logic [AW-1:0]         wt_wa,
	output logic [WW-1:0]         wt_wd,
	input  wire logic [AW-1:0]    par_rd,
	input  wire logic [WW-1:0]    wt_rd,
	output wuf_pkg::alu_op_t      alu_op,
	output logic [DW-1:0]         alu_a,
	output logic [DW-1:0]         alu_b,
	input  wire logic [DW:0]      alu_res,
	input  wire logic             alu_eq,
	input  wire logic             alu_lt
);
	import wuf_pkg::*;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK_P,
		ST_WALK_Q,
		ST_ROOTS,
		ST_WT_P,
		ST_WT_Q,
		ST_WCMP,
		ST_LINK,
		ST_FLAT_P,
		ST_FLAT_Q,
		ST_FINISH
	} state_t;

	state_t        state_q;
	logic [AW-1:0] clr_q;
	logic          kind_q;
	logic [AW-1:0] p_q, q_q, node_q, rp_q, rq_q, root_q, child_q, res_root_q;
	logic [WW-1:0] wp_q, wq_q;
	logic [SW-1:0] sets_q;
	logic          merged_q;
	logic          rsp_valid_q;
	rsp_t          rsp_q;
	logic          out_free;
	logic          bad_req;

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign out_free  = !rsp_valid_q || rsp_ready;

	// a request naming a site at or above SITES is answered with root 0 and no merge
	assign bad_req = (32'(req.site_p) >= 32'(SITES)) ||
		((req.req_type == REQ_UNION) && (32'(req.site_q) >= 32'(SITES)));

	// shared unit operands
	always_comb begin
		alu_op = ALU_SUB;
		alu_a  = '0;
		alu_b  = '0;
		case (state_q)
			ST_WALK_P, ST_WALK_Q, ST_FLAT_P, ST_FLAT_Q: begin
				alu_a = DW'(par_rd);
				alu_b = DW'(node_q);
			end
			ST_ROOTS: begin
				alu_a = DW'(rp_q);
				alu_b = DW'(rq_q);
			end
			ST_WCMP: begin
				alu_a = DW'(wp_q);
				alu_b = DW'(wq_q);
			end
			ST_LINK: begin
				alu_op = ALU_ADD;
				alu_a  = DW'(wp_q);
				alu_b  = DW'(wq_q);
			end
			default: begin
				alu_op = ALU_SUB;
			end
		endcase
	end

	// memory ports
	always_comb begin
		rd_addr = node_q;
		par_we  = 1'b0;
		par_wa  = node_q;
		par_wd  = root_q;
		wt_we   = 1'b0;
		wt_wa   = root_q;
		wt_wd   = WW'(alu_res);
		case (state_q)
			ST_CLEAR: begin
				par_we = 1'b1;
				par_wa = clr_q;
				par_wd = clr_q;
				wt_we  = 1'b1;
				wt_wa  = clr_q;
				wt_wd  = WW'(1);
			end
			ST_IDLE: begin
				rd_addr = req.site_p[AW-1:0];
			end
			ST_WALK_P: begin
				rd_addr = alu_eq ? q_q : par_rd;
			end
			ST_WALK_Q: begin
				rd_addr = par_rd;
			end
			ST_ROOTS: begin
				rd_addr = rp_q;
			end
			ST_WT_P: begin
				rd_addr = rq_q;
			end
			ST_LINK: begin
				rd_addr = p_q;
				par_we  = 1'b1;
				par_wa  = child_q;
				par_wd  = root_q;
				wt_we   = 1'b1;
				wt_wa   = root_q;
			end
			ST_FLAT_P: begin
				rd_addr = alu_eq ? q_q : par_rd;
				par_we  = !alu_eq;
			end
			ST_FLAT_Q: begin
				rd_addr = par_rd;
				par_we  = !alu_eq;
			end
			default: begin
				rd_addr = node_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			sets_q      <= SW'(SITES);
			rsp_valid_q <= 1'b0;
		end else begin
			// in ST_FINISH the result register is handled below
			if (rsp_valid_q && rsp_ready && (state_q != ST_FINISH)) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_valid) begin
						kind_q     <= req.req_type;
						p_q        <= req.site_p[AW-1:0];
						q_q        <= req.site_q[AW-1:0];
						node_q     <= req.site_p[AW-1:0];
						merged_q   <= 1'b0;
						res_root_q <= '0;
						state_q    <= bad_req ? ST_FINISH : ST_WALK_P;
					end
				end
				ST_WALK_P: begin
					if (alu_eq) begin
						rp_q       <= node_q;
						res_root_q <= node_q;
						node_q     <= q_q;
						state_q    <= (kind_q == REQ_UNION) ? ST_WALK_Q : ST_FINISH;
					end else begin
						node_q <= par_rd;
					end
				end
				ST_WALK_Q: begin
					if (alu_eq) begin
						rq_q    <= node_q;
						state_q <= ST_ROOTS;
					end else begin
						node_q <= par_rd;
					end
				end
				ST_ROOTS: begin
					// same set: result is the common root, nothing changes
					state_q <= alu_eq ? ST_FINISH : ST_WT_P;
				end
				ST_WT_P: begin
					wp_q    <= wt_rd;
					state_q <= ST_WT_Q;
				end
				ST_WT_Q: begin
					wq_q    <= wt_rd;
					state_q <= ST_WCMP;
				end
				ST_WCMP: begin
					// ties keep p's root
					if (alu_lt) begin
						root_q  <= rq_q;
						child_q <= rp_q;
					end else begin
						root_q  <= rp_q;
						child_q <= rq_q;
					end
					state_q <= ST_LINK;
				end
				ST_LINK: begin
					sets_q     <= sets_q - 1'b1;
					merged_q   <= 1'b1;
					res_root_q <= root_q;
					node_q     <= p_q;
					state_q    <= ST_FLAT_P;
				end
				ST_FLAT_P: begin
					if (alu_eq) begin
						node_q  <= q_q;
						state_q <= ST_FLAT_Q;
					end else begin
						node_q <= par_rd;
					end
				end
				ST_FLAT_Q: begin
					if (alu_eq) begin
						state_q <= ST_FINISH;
					end else begin
						node_q <= par_rd;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						rsp_valid_q       <= 1'b1;
						rsp_q.result_root <= SITE_W'(res_root_q);
						rsp_q.merged      <= merged_q;
						rsp_q.sets_left   <= SETS_W'(sets_q);
						state_q           <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[rtl/core/weighted_union_find.sv]
// Weighted union-find engine: finds and unions over SITES elements, with the
// smaller tree hung under the larger and, on a merge, both union paths flattened.
// Depends on wuf_pkg, wuf_alu, wuf_store and wuf_ctrl.
`default_nettype none

// One request at a time. After reset the block sweeps both memories, one
// entry a cycle, over min(SITES, 1024) entries before it raises req_ready.
// A find walks from its site to the root. A union walks both sites to their
// roots and, if they differ, reads both tree weights, links the smaller
// tree's root under the larger's and then flattens each path to the new root.
// A result still waiting holds the sequencer until it is taken. The
// parent-link memory's single read port sets the pace: one link followed per
// cycle. The next request is taken in the cycle after a result is
// registered, while that result may still wait.
module weighted_union_find #(
	parameter int SITES = wuf_pkg::SITES_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire wuf_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output wuf_pkg::rsp_t      rsp
);
	import wuf_pkg::*;

	localparam int DEPTH = (SITES < SITE_SPAN) ? SITES : SITE_SPAN;
	localparam int AW    = $clog2(DEPTH);
	localparam int WW    = $clog2(DEPTH + 1);
	localparam int DW    = (AW > WW) ? AW : WW;

	logic [AW-1:0] rd_addr, par_wa, par_wd, wt_wa, par_rd;
	logic [WW-1:0] wt_wd, wt_rd;
	logic          par_we, wt_we;
	alu_op_t       alu_op;
	logic [DW-1:0] alu_a, alu_b;
	logic [DW:0]   alu_res;
	logic          alu_eq, alu_lt;

	wuf_alu #(.DW(DW)) u_alu (
		.op  (alu_op),
		.a   (alu_a),
		.b   (alu_b),
		.res (alu_res),
		.eq  (alu_eq),
		.lt  (alu_lt)
	);

	wuf_store #(.DEPTH(DEPTH)) u_store (
		.clk     (clk),
		.rd_addr (rd_addr),
		.par_we  (par_we),
		.par_wa  (par_wa),
		.par_wd  (par_wd),
		.wt_we   (wt_we),
		.wt_wa   (wt_wa),
		.wt_wd   (wt_wd),
		.par_rd  (par_rd),
		.wt_rd   (wt_rd)
	);

	wuf_ctrl #(.SITES(SITES)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.rd_addr   (rd_addr),
		.par_we    (par_we),
		.par_wa    (par_wa),
		.par_wd    (par_wd),
		.wt_we     (wt_we),
		.wt_wa     (wt_wa),
		.wt_wd     (wt_wd),
		.par_rd    (par_rd),
		.wt_rd     (wt_rd),
		.alu_op    (alu_op),
		.alu_a     (alu_a),
		.alu_b     (alu_b),
		.alu_res   (alu_res),
		.alu_eq    (alu_eq),
		.alu_lt    (alu_lt)
	);

	// a taken transaction keeps the block busy for at least the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted on back-to-back cycles");

	// a result only appears after the sequencer has been busy
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(!req_ready))
		else $error("result raised without a busy cycle");

	// a tree weight never wraps to zero
	assert property (@(posedge clk) disable iff (!arst_n)
		wt_we |-> wt_wd != '0)
		else $error("tree weight overflow");

endmodule

`default_nettype wire
